/* design/fixed_block_pool_allocator_macros.svh */
// assertion helpers for the block pool allocator
// each expects i_clk and i_rst_n in the scope where it is used
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// condition holds at every edge outside reset
`define FBPA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FBPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* design/fbpa_pkg.sv */
package fbpa_pkg;

    localparam int OPCODE_W    = 2;
    localparam int REQ_BYTES_W = 17;
    localparam int REQ_ALIGN_W = 13;
    localparam int BSIZE_W     = 17;
    localparam int EBLK_W      = 18;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int TOTAL_W     = 32;

    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REBUILD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ALIGN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS     = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_ALIGN   = 3'd2,
        ST_LARGE   = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_FOREIGN = 3'd5,
        ST_NULL    = 3'd6,
        ST_OVER    = 3'd7
    } t_status;

    typedef struct packed {
        logic done;
        logic exact;
    } t_div_stat;

    // below 8 acts as 8, otherwise highest power of two
    function automatic logic [REQ_ALIGN_W-1:0] eff_align(input logic [REQ_ALIGN_W-1:0] a);
        logic [REQ_ALIGN_W-1:0] p;
        p = REQ_ALIGN_W'(8);
        for (int i = 3; i < REQ_ALIGN_W; i++) begin
            if (a[i]) begin
                p = REQ_ALIGN_W'(1) << i;
            end
        end
        return p;
    endfunction

    // at least 8 bytes, rounded up to the alignment
    function automatic logic [EBLK_W-1:0] eff_block(input logic [BSIZE_W-1:0] bs,
                                                    input logic [REQ_ALIGN_W-1:0] ea);
        logic [EBLK_W-1:0] b;
        logic [EBLK_W-1:0] m;
        b = (bs < BSIZE_W'(8)) ? EBLK_W'(8) : EBLK_W'(bs);
        m = EBLK_W'(ea) - EBLK_W'(1);
        return (b + m) & ~m;
    endfunction

endpackage

/* design/fbpa_ram.sv */
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/fbpa_div.sv */
module fbpa_div #(
    parameter int QW  = 8,
    parameter int DVW = 18,
    localparam int DW = QW + DVW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DW-1:0]         i_dividend,
    input  logic [DVW-1:0]        i_divisor,
    output logic [QW-1:0]         o_quot,
    output fbpa_pkg::t_div_stat   o_stat
);

    import fbpa_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          w_ge;
    t_div_stat     w_stat;

    // restoring division, one quotient bit a cycle, dividend below 2^QW times divisor
    assign w_ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dvs  <= DW'(i_divisor) << (QW - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_quot <= (r_quot << 1) | QW'(w_ge);
            r_dvs  <= r_dvs >> 1;
        end
    end

    always_comb begin
        w_stat.done  = r_done;
        w_stat.exact = (r_rem == '0);
    end

    assign o_stat = w_stat;
    assign o_quot = r_quot;

endmodule

/* design/fixed_block_pool_allocator.sv */
// allocate: S_PREP, S_ACHK, S_ARD, S_AADD, S_OUT; S_ACHK goes to S_OUT on a rejection
// free: S_PREP, S_FCHK0, S_FCHK1, S_DIV, S_OUT, the serial divider giving one index bit a cycle
// rebuild and unused opcode: S_PREP, S_OUT; one item at a time, next input taken the cycle
// after its result is registered, result register lets the next item in while it waits
// synchronous active-low reset: default registers, all blocks free, counters and peak zero
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 256,
    parameter int ADDR_BITS  = 32,
    localparam int CNTW  = $clog2(MAX_BLOCKS + 1),
    localparam int IN_W  = ((fbpa_pkg::REQ_BYTES_W + fbpa_pkg::REQ_ALIGN_W + ADDR_BITS + 7)
                            / 8) * 8,
    localparam int OUT_W = ((ADDR_BITS + 3 * CNTW + 2 * fbpa_pkg::TOTAL_W + 7) / 8) * 8,
    localparam int CFG_W = (ADDR_BITS > fbpa_pkg::BSIZE_W) ? ADDR_BITS : fbpa_pkg::BSIZE_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]                i_cfg_data,
    // requests
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_W-1:0]                 s_axis_tdata,  // req_bytes, req_alignment, free_address
    input  logic [fbpa_pkg::OPCODE_W-1:0]   s_axis_tuser,  // opcode
    // results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_W-1:0]                m_axis_tdata,  // block_address, free_blocks,
                                                           // used_blocks, peak_used,
                                                           // alloc_total, free_total
    output logic [fbpa_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);

    import fbpa_pkg::*;

    localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PW   = CNTW + EBLK_W;
    localparam int DW   = IDXW + EBLK_W;
    localparam int CW   = (ADDR_BITS > PW) ? ADDR_BITS : PW;
    localparam int BIU_RST = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ACHK,
        S_ARD,
        S_AADD,
        S_FCHK0,
        S_FCHK1,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic [CNTW-1:0] nblocks(input logic [CNTW-1:0] v);
        logic [CNTW-1:0] r;
        if (v == '0) begin
            r = CNTW'(1);
        end else if (v > CNTW'(MAX_BLOCKS)) begin
            r = CNTW'(MAX_BLOCKS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    t_state                 r_state;
    logic [OPCODE_W-1:0]    r_op;
    logic [REQ_BYTES_W-1:0] r_bytes;
    logic [REQ_ALIGN_W-1:0] r_ralign;
    logic [ADDR_BITS-1:0]   r_faddr;
    logic [ADDR_BITS-1:0]   r_off;
    logic [REQ_ALIGN_W-1:0] r_ea;
    logic [EBLK_W-1:0]      r_eb;
    logic [CNTW-1:0]        r_n;
    logic [PW-1:0]          r_prod;
    logic [ADDR_BITS-1:0]   r_addr;
    t_status                r_status;
    logic                   r_from_mem;

    logic [CNTW-1:0]        r_top;
    logic [CNTW-1:0]        r_low;
    logic [CNTW-1:0]        r_peak;
    logic [TOTAL_W-1:0]     r_alloc_cnt;
    logic [TOTAL_W-1:0]     r_free_cnt;

    logic [ADDR_BITS-1:0]   r_base;
    logic [BSIZE_W-1:0]     r_bsize;
    logic [REQ_ALIGN_W-1:0] r_palign;
    logic [CNTW-1:0]        r_biu;

    logic                   r_m_tvalid;
    logic [OUT_W-1:0]       r_m_tdata;
    logic [STATUS_W-1:0]    r_m_tuser;

    logic [CNTW-1:0]        w_n;
    logic [CNTW-1:0]        w_top_dec;
    logic [CNTW-1:0]        w_used;
    logic [IDXW-1:0]        w_idx;
    logic [CNTW-1:0]        w_mul_a;
    logic                   w_outside;
    logic                   w_align_bad;
    logic [IDXW-1:0]        w_ram_q;
    logic                   w_ram_we;
    logic                   w_div_start;
    logic [IDXW-1:0]        w_quot;
    t_div_stat              w_div_stat;

    assign w_n       = nblocks(r_biu);
    assign w_top_dec = r_top - 1'b1;
    assign w_used    = w_n - r_top;

    // stack slots below the low mark take their rebuild value, their own index, not the RAM
    assign w_idx     = r_from_mem ? w_ram_q : r_top[IDXW-1:0];
    assign w_mul_a   = (r_state == S_ARD) ? CNTW'(w_idx) : r_n;
    assign w_outside = (CW'(r_off) >= CW'(r_prod));

    assign w_align_bad = (r_ralign == '0)
                      || ((r_ralign & (r_ralign - 1'b1)) != '0)
                      || (r_ralign > r_ea);

    assign w_div_start = (r_state == S_FCHK1) && !w_outside;
    assign w_ram_we    = (r_state == S_DIV) && w_div_stat.done && w_div_stat.exact
                      && (r_top < r_n);

    fbpa_ram #(
        .WIDTH (IDXW),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_top[IDXW-1:0]),
        .i_wdata (w_quot),
        .i_raddr (w_top_dec[IDXW-1:0]),
        .o_rdata (w_ram_q)
    );

    fbpa_div #(
        .QW  (IDXW),
        .DVW (EBLK_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (DW'(r_off)),
        .i_divisor  (r_eb),
        .o_quot     (w_quot),
        .o_stat     (w_div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m_tvalid  <= 1'b0;
            r_base      <= '0;
            r_bsize     <= BSIZE_W'(64);
            r_palign    <= REQ_ALIGN_W'(16);
            r_biu       <= CNTW'(BIU_RST);
            r_top       <= nblocks(CNTW'(BIU_RST));
            r_low       <= nblocks(CNTW'(BIU_RST));
            r_peak      <= '0;
            r_alloc_cnt <= '0;
            r_free_cnt  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POOL_BASE:  r_base   <= i_cfg_data[ADDR_BITS-1:0];
                    CFG_BLOCK_SIZE: r_bsize  <= i_cfg_data[BSIZE_W-1:0];
                    CFG_POOL_ALIGN: r_palign <= i_cfg_data[REQ_ALIGN_W-1:0];
                    CFG_BLOCKS: begin
                        r_biu <= i_cfg_data[CNTW-1:0];
                        r_top <= nblocks(i_cfg_data[CNTW-1:0]);
                        r_low <= nblocks(i_cfg_data[CNTW-1:0]);
                    end
                    default: ;
                endcase
            end

            // in S_OUT the register is reloaded below instead
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tuser;
                        r_bytes  <= s_axis_tdata[REQ_BYTES_W-1:0];
                        r_ralign <= s_axis_tdata[REQ_BYTES_W +: REQ_ALIGN_W];
                        r_faddr  <= s_axis_tdata[REQ_BYTES_W + REQ_ALIGN_W +: ADDR_BITS];
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_ea     <= eff_align(r_palign);
                    r_eb     <= eff_block(r_bsize, eff_align(r_palign));
                    r_n      <= w_n;
                    r_off    <= r_faddr - r_base;
                    r_addr   <= '0;
                    r_status <= ST_OK;
                    case (r_op)
                        OP_ALLOC: r_state <= S_ACHK;
                        OP_FREE:  r_state <= S_FCHK0;
                        OP_REBUILD: begin
                            r_top   <= w_n;
                            r_low   <= w_n;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_ACHK: begin
                    if (r_bytes == '0) begin
                        r_status <= ST_ZERO;
                        r_state  <= S_OUT;
                    end else if (w_align_bad) begin
                        r_status <= ST_ALIGN;
                        r_state  <= S_OUT;
                    end else if (EBLK_W'(r_bytes) > r_eb) begin
                        r_status <= ST_LARGE;
                        r_state  <= S_OUT;
                    end else if (r_top == '0) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_OUT;
                    end else begin
                        // pop: the read of slot top-1 was issued this cycle
                        r_top      <= w_top_dec;
                        r_from_mem <= (w_top_dec >= r_low);
                        if (w_top_dec < r_low) begin
                            r_low <= w_top_dec;
                        end
                        r_state <= S_ARD;
                    end
                end
                S_ARD: begin
                    r_prod  <= PW'(w_mul_a) * PW'(r_eb);
                    r_state <= S_AADD;
                end
                S_AADD: begin
                    r_addr <= ADDR_BITS'(CW'(r_base) + CW'(r_prod));
                    if (r_alloc_cnt != '1) begin
                        r_alloc_cnt <= r_alloc_cnt + 1'b1;
                    end
                    if (w_used > r_peak) begin
                        r_peak <= w_used;
                    end
                    r_state <= S_OUT;
                end
                S_FCHK0: begin
                    r_prod <= PW'(w_mul_a) * PW'(r_eb);
                    if (r_faddr == '0) begin
                        r_status <= ST_NULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_FCHK1;
                    end
                end
                S_FCHK1: begin
                    if (w_outside) begin
                        r_status <= ST_FOREIGN;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        if (!w_div_stat.exact) begin
                            r_status <= ST_FOREIGN;
                        end else if (r_top >= r_n) begin
                            r_status <= ST_OVER;
                        end else begin
                            r_top <= r_top + 1'b1;
                            if (r_free_cnt != '1) begin
                                r_free_cnt <= r_free_cnt + 1'b1;
                            end
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_tvalid || m_axis_tready) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= OUT_W'({r_free_cnt, r_alloc_cnt, r_peak, w_used,
                                              r_top, r_addr});
                        r_m_tuser  <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // registers change only between items
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    `FBPA_ASSERT_ALWAYS(a_top_in_region, r_top <= w_n, "free count above block count")
    `FBPA_ASSERT_ALWAYS(a_low_mark, r_low <= r_top, "low mark above stack top")
    `FBPA_ASSERT_IMP(a_div_owner, w_div_stat.done, r_state == S_DIV, "divider done while not waiting")
    `FBPA_ASSERT_IMP(a_alloc_step, $past(i_rst_n) && (r_alloc_cnt != $past(r_alloc_cnt)), r_alloc_cnt == $past(r_alloc_cnt) + 1'b1, "allocation count jumped")

endmodule
